// ----- rtl/core/irkm_pkg.sv -----
// ----------------------------------------------------------------------------
// irkm_pkg
// Shared types, codes and entry helpers for the IR code to key map table.
// ----------------------------------------------------------------------------
`default_nettype none

package irkm_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned MAX_OUT     = 64;
  localparam int unsigned NOUT_W      = $clog2(MAX_OUT + 1);

  // entry layout from the low end: protocol 8, address 16, command 16,
  // report id 8, key 16
  typedef logic [63:0] entry_t;
  typedef logic [39:0] code_t;

  // input kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_LAST   = 2'd3;

  // result types
  localparam logic [2:0] RES_KEYBOARD = 3'd0;
  localparam logic [2:0] RES_CONSUMER = 3'd1;
  localparam logic [2:0] RES_STATUS   = 3'd2;
  localparam logic [2:0] RES_ENTRY    = 3'd3;
  localparam logic [2:0] RES_LASTCODE = 3'd4;

  // configuration register indexes
  localparam logic CFG_KEYBOARD_ID = 1'b0;
  localparam logic CFG_CONSUMER_ID = 1'b1;

  localparam logic [7:0] RID_FREE_LO = 8'h00;
  localparam logic [7:0] RID_FREE_HI = 8'hff;

  function automatic code_t code_of(input entry_t e);
    code_of = e[39:0];
  endfunction

  function automatic logic [7:0] rid_of(input entry_t e);
    rid_of = e[47:40];
  endfunction

  function automatic logic [15:0] key_of(input entry_t e);
    key_of = e[63:48];
  endfunction

  function automatic logic is_free(input entry_t e);
    is_free = (e[47:40] == RID_FREE_LO) || (e[47:40] == RID_FREE_HI);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ir_code_to_key_map_table.sv -----
// Sequencing: lookup, write and entry read scan one full turn of the entry ring,
//   one entry per cycle unless an output stall holds a pending key beat, and then
//   give any final beat from the finish state; a last code read goes straight to
//   the finish state. A new item is taken only while the block is idle.
// Reset: async active low; every entry erased to all ones, last code zeroed,
//   keyboard id 1, consumer id 2; no clearing pass.
// ----------------------------------------------------------------------------
// ir_code_to_key_map_table
// Maps decoded IR codes to HID key beats through a rotating ring of entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_code_to_key_map_table
  import irkm_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write port
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [7:0]  cfg_wdata_i,
  // item channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [7:0]  protocol_i,
  input  wire  [15:0] address_i,
  input  wire  [15:0] command_i,
  input  wire  [7:0]  report_id_i,
  input  wire  [15:0] key_code_i,
  input  wire  [7:0]  index_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  result_type_o,
  output logic [7:0]  out_protocol_o,
  output logic [15:0] out_address_o,
  output logic [15:0] out_command_o,
  output logic [7:0]  out_report_id_o,
  output logic [15:0] out_key_o,
  output logic        write_status_o,
  output logic        last_o
);

  // report id registers
  logic [7:0] kbd_id_q;
  logic [7:0] cons_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_id_q  <= 8'd1;
      cons_id_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEYBOARD_ID: kbd_id_q  <= cfg_wdata_i;
        CFG_CONSUMER_ID: cons_id_q <= cfg_wdata_i;
        default:         kbd_id_q  <= kbd_id_q;
      endcase
    end
  end

  // The ring turns one place per cycle during a scan while no output stall holds
  // it, so cell 0 always holds entry number cnt. A full turn restores the original
  // order; a write swaps the new entry in at the tail as the target leaves the head.
  entry_t ring [ENTRIES];
  entry_t tail;
  logic   shift;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t nxt;
    if (i == ENTRIES - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = ring[i+1];
    end
    irkm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (nxt),
      .q_o     (ring[i])
    );
  end

  // sequencer: matching at the head, pending key so the final beat gets last
  irkm_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .protocol_i      (protocol_i),
    .address_i       (address_i),
    .command_i       (command_i),
    .report_id_i     (report_id_i),
    .key_code_i      (key_code_i),
    .index_i         (index_i),
    .kbd_id_i        (kbd_id_q),
    .cons_id_i       (cons_id_q),
    .head_i          (ring[0]),
    .shift_o         (shift),
    .tail_o          (tail),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_type_o   (result_type_o),
    .out_protocol_o  (out_protocol_o),
    .out_address_o   (out_address_o),
    .out_command_o   (out_command_o),
    .out_report_id_o (out_report_id_o),
    .out_key_o       (out_key_o),
    .write_status_o  (write_status_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/irkm_cell.sv -----
// ----------------------------------------------------------------------------
// irkm_cell
// One table entry of the rotating ring; takes its neighbour's entry on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module irkm_cell
  import irkm_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    shift_i,
  input  entry_t d_i,
  output entry_t q_o
);

  entry_t entry_q;

  // erased state is all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '1;
    end else if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

// ----- rtl/core/irkm_ctrl.sv -----
// ----------------------------------------------------------------------------
// irkm_ctrl
// Scan sequencer at the head of the ring: matching, write-back, result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module irkm_ctrl
  import irkm_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // item channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [7:0]  protocol_i,
  input  wire  [15:0] address_i,
  input  wire  [15:0] command_i,
  input  wire  [7:0]  report_id_i,
  input  wire  [15:0] key_code_i,
  input  wire  [7:0]  index_i,
  // configuration
  input  wire  [7:0]  kbd_id_i,
  input  wire  [7:0]  cons_id_i,
  // ring head and feedback
  input  entry_t      head_i,
  output logic        shift_o,
  output entry_t      tail_o,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  result_type_o,
  output logic [7:0]  out_protocol_o,
  output logic [15:0] out_address_o,
  output logic [15:0] out_command_o,
  output logic [7:0]  out_report_id_o,
  output logic [15:0] out_key_o,
  output logic        write_status_o,
  output logic        last_o
);

  localparam int unsigned CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic              pend_valid_q;
  logic [NOUT_W-1:0] nout_q;
  logic              out_valid_q;

  // item payload
  logic [1:0]  kind_q;
  code_t       code_q;
  logic [7:0]  rid_q;
  logic [15:0] key_q;
  logic [7:0]  idx_q;
  entry_t      rd_q;
  logic        pend_cons_q;
  logic [15:0] pend_key_q;

  // last received code
  logic [7:0]  last_prot_q;
  logic [15:0] last_addr_q;
  logic [15:0] last_cmd_q;

  // result register
  logic [2:0]  res_type_q;
  logic [7:0]  res_prot_q;
  logic [15:0] res_addr_q;
  logic [15:0] res_cmd_q;
  logic [7:0]  res_rid_q;
  logic [15:0] res_key_q;
  logic        res_st_q;
  logic        res_last_q;

  logic head_match, head_free, rid_kbd, rid_cons, cap_hit;
  logic lk_hit, lk_stop, wr_hit, push_pend, out_free, advance, fin_emit, load;
  logic scan_end, in_fire;

  assign head_match = (code_of(head_i) == code_q);
  assign head_free  = is_free(head_i);
  assign rid_kbd    = (rid_of(head_i) == kbd_id_i);
  assign rid_cons   = (rid_of(head_i) == cons_id_i);
  assign cap_hit    = (nout_q == NOUT_W'(MAX_OUT));

  assign lk_hit  = (state_q == ST_SCAN) && (kind_q == KIND_LOOKUP) && !done_q && !head_free
                   && head_match && !cap_hit && (rid_kbd || rid_cons);
  assign lk_stop = (kind_q == KIND_LOOKUP) && !done_q && (head_free || (head_match && cap_hit));
  assign wr_hit  = (state_q == ST_SCAN) && (kind_q == KIND_WRITE) && !done_q
                   && (head_match || head_free);

  assign push_pend = lk_hit && pend_valid_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance   = (state_q == ST_SCAN) && (!push_pend || out_free);
  assign scan_end  = (cnt_q == CW'(ENTRIES - 1));
  assign fin_emit  = (state_q == ST_FIN) && ((kind_q != KIND_LOOKUP) || pend_valid_q);
  assign load      = (advance && push_pend) || (fin_emit && out_free);
  assign in_fire   = in_valid_i && (state_q == ST_IDLE);

  assign in_stall_o = (state_q != ST_IDLE);
  assign shift_o    = advance;
  assign tail_o     = wr_hit ? {key_q, rid_q, code_q} : head_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == KIND_LAST) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && scan_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!fin_emit || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      done_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      nout_q       <= '0;
      out_valid_q  <= 1'b0;
      last_prot_q  <= '0;
      last_addr_q  <= '0;
      last_cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q        <= '0;
        done_q       <= 1'b0;
        pend_valid_q <= 1'b0;
        nout_q       <= '0;
        if (kind_i == KIND_LOOKUP) begin
          last_prot_q <= protocol_i;
          last_addr_q <= address_i;
          last_cmd_q  <= command_i;
        end
      end
      if (advance) begin
        cnt_q <= cnt_q + CW'(1);
        if (lk_stop || wr_hit) begin
          done_q <= 1'b1;
        end
        if (lk_hit) begin
          pend_valid_q <= 1'b1;
          nout_q       <= nout_q + NOUT_W'(1);
        end
      end
      if (fin_emit && out_free && (kind_q == KIND_LAST)) begin
        last_prot_q <= '0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      code_q <= {command_i, address_i, protocol_i};
      rid_q  <= report_id_i;
      key_q  <= key_code_i;
      idx_q  <= index_i;
      rd_q   <= '0;
    end
    if (advance && (kind_q == KIND_READ) && (cnt_q == idx_q[CW-1:0])
        && ({1'b0, idx_q} < 9'(ENTRIES))) begin
      rd_q <= head_i;
    end
    if (advance && lk_hit) begin
      pend_cons_q <= !rid_kbd;
      pend_key_q  <= key_of(head_i);
    end
    if (load) begin
      res_prot_q <= '0;
      res_addr_q <= '0;
      res_cmd_q  <= '0;
      res_rid_q  <= '0;
      res_key_q  <= '0;
      res_st_q   <= 1'b0;
      res_last_q <= (state_q == ST_FIN);
      res_type_q <= RES_STATUS;
      if (state_q == ST_SCAN || kind_q == KIND_LOOKUP) begin
        res_type_q <= pend_cons_q ? RES_CONSUMER : RES_KEYBOARD;
        res_key_q  <= pend_key_q;
      end else begin
        case (kind_q)
          KIND_WRITE: begin
            res_type_q <= RES_STATUS;
            res_st_q   <= !done_q;
          end
          KIND_READ: begin
            res_type_q <= RES_ENTRY;
            res_prot_q <= rd_q[7:0];
            res_addr_q <= rd_q[23:8];
            res_cmd_q  <= rd_q[39:24];
            res_rid_q  <= rid_of(rd_q);
            res_key_q  <= key_of(rd_q);
          end
          KIND_LAST: begin
            res_type_q <= RES_LASTCODE;
            res_prot_q <= last_prot_q;
            res_addr_q <= last_addr_q;
            res_cmd_q  <= last_cmd_q;
          end
          default: res_type_q <= RES_STATUS;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_type_o   = res_type_q;
  assign out_protocol_o  = res_prot_q;
  assign out_address_o   = res_addr_q;
  assign out_command_o   = res_cmd_q;
  assign out_report_id_o = res_rid_q;
  assign out_key_o       = res_key_q;
  assign write_status_o  = res_st_q;
  assign last_o          = res_last_q;

endmodule

`default_nettype wire
